// ----- src/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types and constants of the pivot fault classifier.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int ADDR_W    = 10;
  localparam int CAP_W     = 5;
  localparam int OUT_CNT_W = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CAP_W-1:0] PCAP_RESET = 5'd16;
  localparam logic [CAP_W-1:0] BCAP_RESET = 5'd4;

  typedef enum logic [1:0] {
    FC_PIVOT    = 2'd0,
    FC_BUFFER   = 2'd1,
    FC_NONPIVOT = 2'd2,
    FC_OVERFLOW = 2'd3
  } fault_class_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIVOT_CAP  = 1'b0,
    REG_BUFFER_CAP = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } pfc_state_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } scan_tok_t;

endpackage

// ----- src/pfc_cell.sv -----
// ----------------------------------------------------------------------------
// pfc_cell
// One pivot entry: holds a row/column pair, compares the passing key and
// forwards the key and the accumulated hit flag to the next cell.
// ----------------------------------------------------------------------------
module pfc_cell #(
  parameter int ROW_WIDTH = 10,
  parameter int COL_WIDTH = 10,
  parameter int CNT_W     = 5,
  parameter int IDX       = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [CNT_W-1:0]        cnt,
  input  logic                    wr_en,
  input  logic [CNT_W-1:0]        wr_idx,
  input  logic [ROW_WIDTH-1:0]    wr_row,
  input  logic [COL_WIDTH-1:0]    wr_col,
  input  pfc_pkg::scan_tok_t      tok_in,
  input  logic [ROW_WIDTH-1:0]    row_in,
  input  logic [COL_WIDTH-1:0]    col_in,
  output pfc_pkg::scan_tok_t      tok_out,
  output logic [ROW_WIDTH-1:0]    row_out,
  output logic [COL_WIDTH-1:0]    col_out
);
  import pfc_pkg::*;

  logic [ROW_WIDTH-1:0] row_r;
  logic [COL_WIDTH-1:0] col_r;
  logic [ROW_WIDTH-1:0] row_fwd_r;
  logic [COL_WIDTH-1:0] col_fwd_r;
  scan_tok_t            tok_r;
  scan_tok_t            tok_nxt;
  logic                 active;
  logic                 match;

  // entry is live only below the pivot count
  assign active = cnt > CNT_W'(IDX);
  assign match  = active && ((row_r == row_in) || (col_r == col_in));

  always_comb begin
    tok_nxt.valid = tok_in.valid;
    tok_nxt.hit   = tok_in.hit | (tok_in.valid & match);
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == CNT_W'(IDX))) begin
      row_r <= wr_row;
      col_r <= wr_col;
    end
  end

  always_ff @(posedge clk) begin
    row_fwd_r <= row_in;
    col_fwd_r <= col_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;
  assign row_out = row_fwd_r;
  assign col_out = col_fwd_r;

endmodule

// ----- src/pivot_fault_classifier.sv -----
// ----------------------------------------------------------------------------
// pivot_fault_classifier
// Pivot-fault redundancy analysis for one memory subarray.
// ----------------------------------------------------------------------------
// Each request carries one faulty cell address and returns one result: the
// fault class, the pivot and buffer counts after the fault and the two sticky
// array flags. After acceptance the key is registered at the head of the row,
// walks the row of pivot cells one cell per clock, then hit_r latches the hit
// and the commit state writes the class and counts before the next request
// can be accepted. The commit waits while an earlier result still sits unread
// in the output register. Otherwise the next request is taken while the result
// still waits for out_ready.
// new_array set on a request clears counts and flags before it is classified.
module pivot_fault_classifier #(
  parameter int PIVOT_ENTRIES  = 16,
  parameter int BUFFER_ENTRIES = 16,
  parameter int ROW_WIDTH      = 10,
  parameter int COL_WIDTH      = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfc_pkg::CAP_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_new_array,
  input  logic [pfc_pkg::ADDR_W-1:0]     in_row_addr,
  input  logic [pfc_pkg::ADDR_W-1:0]     in_col_addr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_fault_class,
  output logic [pfc_pkg::OUT_CNT_W-1:0]  out_pivots_held,
  output logic [pfc_pkg::OUT_CNT_W-1:0]  out_buffers_held,
  output logic                           out_buffer_in_use,
  output logic                           out_unrepairable
);
  import pfc_pkg::*;

  localparam int PCNT_W = $clog2(PIVOT_ENTRIES + 1);
  localparam int BCNT_W = $clog2(BUFFER_ENTRIES + 1);
  localparam int CMP_P  = (PCNT_W > CAP_W) ? PCNT_W : CAP_W;
  localparam int CMP_B  = (BCNT_W > CAP_W) ? BCNT_W : CAP_W;

  pfc_state_t state_r, state_nxt;

  logic [CAP_W-1:0] pcap_r;
  logic [CAP_W-1:0] bcap_r;

  logic [PCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [BCNT_W-1:0] bcnt_r, bcnt_nxt;
  logic              bused_r, bused_nxt;
  logic              ovf_r, ovf_nxt;
  logic              hit_r;

  logic [ROW_WIDTH-1:0] q_row_r;
  logic [COL_WIDTH-1:0] q_col_r;
  scan_tok_t            head_tok_r;

  logic                 accept;
  logic                 commit;
  logic                 out_free;
  logic                 wr_en;
  logic                 pivot_room;
  logic                 buffer_room;
  fault_class_t         cls;

  logic [ROW_WIDTH+ADDR_W-1:0] row_ext;
  logic [COL_WIDTH+ADDR_W-1:0] col_ext;
  logic [ROW_WIDTH-1:0]        row_key;
  logic [COL_WIDTH-1:0]        col_key;

  logic [PCNT_W+OUT_CNT_W-1:0] pcnt_ext;
  logic [BCNT_W+OUT_CNT_W-1:0] bcnt_ext;

  logic                        out_valid_r;
  fault_class_t                out_cls_r;
  logic [OUT_CNT_W-1:0]        out_piv_r;
  logic [OUT_CNT_W-1:0]        out_buf_r;
  logic                        out_bused_r;
  logic                        out_ovf_r;

  scan_tok_t            tok   [PIVOT_ENTRIES+1];
  logic [ROW_WIDTH-1:0] row_c [PIVOT_ENTRIES+1];
  logic [COL_WIDTH-1:0] col_c [PIVOT_ENTRIES+1];
  logic [PIVOT_ENTRIES:0] tok_valid;

  assign row_ext = {{ROW_WIDTH{1'b0}}, in_row_addr};
  assign col_ext = {{COL_WIDTH{1'b0}}, in_col_addr};
  assign row_key = row_ext[ROW_WIDTH-1:0];
  assign col_key = col_ext[COL_WIDTH-1:0];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcap_r <= PCAP_RESET;
      bcap_r <= BCAP_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PIVOT_CAP:  pcap_r <= cfg_wdata;
        REG_BUFFER_CAP: bcap_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // cell row
  assign tok[0]   = head_tok_r;
  assign row_c[0] = q_row_r;
  assign col_c[0] = q_col_r;

  for (genvar g = 0; g < PIVOT_ENTRIES; g++) begin : g_cell
    pfc_cell #(
      .ROW_WIDTH (ROW_WIDTH),
      .COL_WIDTH (COL_WIDTH),
      .CNT_W     (PCNT_W),
      .IDX       (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cnt     (pcnt_r),
      .wr_en   (wr_en),
      .wr_idx  (pcnt_r),
      .wr_row  (q_row_r),
      .wr_col  (q_col_r),
      .tok_in  (tok[g]),
      .row_in  (row_c[g]),
      .col_in  (col_c[g]),
      .tok_out (tok[g+1]),
      .row_out (row_c[g+1]),
      .col_out (col_c[g+1])
    );
  end

  for (genvar v = 0; v <= PIVOT_ENTRIES; v++) begin : g_tokv
    assign tok_valid[v] = tok[v].valid;
  end

  // control
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (tok[PIVOT_ENTRIES].valid) state_nxt = ST_COMMIT;
      ST_COMMIT: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_COMMIT: commit   = out_free;
      default: begin
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  assign pivot_room  = (CMP_P'(pcnt_r) < CMP_P'(pcap_r)) &&
                       (pcnt_r < PCNT_W'(PIVOT_ENTRIES));
  assign buffer_room = (CMP_B'(bcnt_r) < CMP_B'(bcap_r)) &&
                       (bcnt_r < BCNT_W'(BUFFER_ENTRIES));

  always_comb begin
    pcnt_nxt  = pcnt_r;
    bcnt_nxt  = bcnt_r;
    bused_nxt = bused_r;
    ovf_nxt   = ovf_r;
    cls       = FC_PIVOT;
    wr_en     = 1'b0;
    if (accept && in_new_array) begin
      pcnt_nxt  = '0;
      bcnt_nxt  = '0;
      bused_nxt = 1'b0;
      ovf_nxt   = 1'b0;
    end else if (commit) begin
      if ((pcnt_r == '0) || (!hit_r && pivot_room)) begin
        wr_en    = 1'b1;
        pcnt_nxt = pcnt_r + PCNT_W'(1);
        cls      = FC_PIVOT;
      end else if (hit_r) begin
        cls = FC_NONPIVOT;
      end else if (buffer_room) begin
        bcnt_nxt  = bcnt_r + BCNT_W'(1);
        bused_nxt = 1'b1;
        cls       = FC_BUFFER;
      end else begin
        ovf_nxt = 1'b1;
        cls     = FC_OVERFLOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pcnt_r     <= '0;
      bcnt_r     <= '0;
      bused_r    <= 1'b0;
      ovf_r      <= 1'b0;
      head_tok_r <= '0;
    end else begin
      state_r          <= state_nxt;
      pcnt_r           <= pcnt_nxt;
      bcnt_r           <= bcnt_nxt;
      bused_r          <= bused_nxt;
      ovf_r            <= ovf_nxt;
      head_tok_r.valid <= accept;
      head_tok_r.hit   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_row_r <= row_key;
      q_col_r <= col_key;
    end
    if (tok[PIVOT_ENTRIES].valid) begin
      hit_r <= tok[PIVOT_ENTRIES].hit;
    end
  end

  // result register
  assign pcnt_ext = {{OUT_CNT_W{1'b0}}, pcnt_nxt};
  assign bcnt_ext = {{OUT_CNT_W{1'b0}}, bcnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_cls_r   <= cls;
      out_piv_r   <= pcnt_ext[OUT_CNT_W-1:0];
      out_buf_r   <= bcnt_ext[OUT_CNT_W-1:0];
      out_bused_r <= bused_nxt;
      out_ovf_r   <= ovf_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fault_class   = out_cls_r;
  assign out_pivots_held   = out_piv_r;
  assign out_buffers_held  = out_buf_r;
  assign out_buffer_in_use = out_bused_r;
  assign out_unrepairable  = out_ovf_r;

  // checks
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_valid) <= 1)
    else $error("more than one compare token in the cell row");

  a_token_exit_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok[PIVOT_ENTRIES].valid |-> state_r == ST_SCAN)
    else $error("compare token left the row outside a scan");

  a_pivot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PCNT_W'(PIVOT_ENTRIES))
    else $error("pivot count above store size");

  a_buffer_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= BCNT_W'(BUFFER_ENTRIES))
    else $error("buffer count above store size");

  a_pivot_grows: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> pcnt_r == $past(pcnt_r) + PCNT_W'(1))
    else $error("pivot write without count increment");

endmodule

// ----- dv/pivot_fault_classifier_tb.sv -----
// ----------------------------------------------------------------------------
// pivot_fault_classifier_tb
// Self-checking bench for the pivot fault classifier.
// ----------------------------------------------------------------------------
// A short directed table covers the reset state, address extremes, each fault
// class, zero pivot capacity and the sticky flags. Random faults then follow,
// grouped into arrays, over several capacity settings. Every request is
// classified by a local pivot/buffer model, and each result is checked field
// by field in order. Both channels are throttled at random before segment 6.
`timescale 1ns / 1ps

module pivot_fault_classifier_tb;
  import pfc_pkg::*;

  localparam int PIVOT_ENTRIES  = 16;
  localparam int BUFFER_ENTRIES = 16;
  localparam int PLAN_LEN       = 24;
  localparam int SEGMENTS       = 8;
  localparam int SEG_ITEMS      = 50;
  localparam int SETTLE_CYCLES  = 40;
  localparam int CYCLE_LIMIT    = 400000;

  typedef struct packed {
    fault_class_t         cls;
    logic [OUT_CNT_W-1:0] pivots;
    logic [OUT_CNT_W-1:0] buffers;
    logic                 in_use;
    logic                 unrep;
  } fault_verdict_t;

  typedef enum logic [1:0] {
    PLAN_PREDICT,
    PLAN_TYPED,
    PLAN_CONFIG
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t     kind;
    logic           na;
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] col;
    logic [CAP_W-1:0]  pcap;
    logic [CAP_W-1:0]  bcap;
    fault_verdict_t    want;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CAP_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_new_array;
  logic [ADDR_W-1:0]    in_row_addr;
  logic [ADDR_W-1:0]    in_col_addr;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_fault_class;
  logic [OUT_CNT_W-1:0] out_pivots_held;
  logic [OUT_CNT_W-1:0] out_buffers_held;
  logic                 out_buffer_in_use;
  logic                 out_unrepairable;

  // classifier model state
  logic [ADDR_W-1:0] piv_row [PIVOT_ENTRIES];
  logic [ADDR_W-1:0] piv_col [PIVOT_ENTRIES];
  logic [CAP_W-1:0]  piv_cnt;
  logic [CAP_W-1:0]  buf_cnt;
  logic              buf_used;
  logic              ovf;
  logic [CAP_W-1:0]  cap_piv;
  logic [CAP_W-1:0]  cap_buf;

  fault_verdict_t pending_verdicts [$];
  fault_verdict_t head;
  int             mismatches = 0;
  int             cycles = 0;
  int             send_idle_pct;
  int             recv_idle_pct;

  logic [CAP_W-1:0] seg_pcap [SEGMENTS] = '{5'd0, 5'd16, 5'd31, 5'd2, 5'd1, 5'd17, 5'd0, 5'd4};
  logic [CAP_W-1:0] seg_bcap [SEGMENTS] = '{5'd0, 5'd16, 5'd31, 5'd3, 5'd0, 5'd1, 5'd0, 5'd16};

  plan_row_t plan [PLAN_LEN] = '{
    '{PLAN_TYPED,   1'b0, 10'd0,    10'd0,    5'd0,  5'd0, '{FC_PIVOT,    5'd1, 5'd0, 1'b0, 1'b0}},
    '{PLAN_TYPED,   1'b0, 10'd0,    10'd1023, 5'd0,  5'd0, '{FC_NONPIVOT, 5'd1, 5'd0, 1'b0, 1'b0}},
    '{PLAN_TYPED,   1'b0, 10'd1023, 10'd0,    5'd0,  5'd0, '{FC_NONPIVOT, 5'd1, 5'd0, 1'b0, 1'b0}},
    '{PLAN_TYPED,   1'b0, 10'd1023, 10'd1023, 5'd0,  5'd0, '{FC_PIVOT,    5'd2, 5'd0, 1'b0, 1'b0}},
    '{PLAN_TYPED,   1'b1, 10'd1023, 10'd1023, 5'd0,  5'd0, '{FC_PIVOT,    5'd1, 5'd0, 1'b0, 1'b0}},
    '{PLAN_PREDICT, 1'b0, 10'h155,  10'h2AA,  5'd0,  5'd0, '0},
    '{PLAN_PREDICT, 1'b0, 10'h2AA,  10'h155,  5'd0,  5'd0, '0},
    '{PLAN_PREDICT, 1'b0, 10'h155,  10'd7,    5'd0,  5'd0, '0},
    '{PLAN_CONFIG,  1'b0, 10'd0,    10'd0,    5'd0,  5'd2, '0},
    '{PLAN_TYPED,   1'b1, 10'd5,    10'd5,    5'd0,  5'd0, '{FC_PIVOT,    5'd1, 5'd0, 1'b0, 1'b0}},
    '{PLAN_TYPED,   1'b0, 10'd6,    10'd6,    5'd0,  5'd0, '{FC_BUFFER,   5'd1, 5'd1, 1'b1, 1'b0}},
    '{PLAN_TYPED,   1'b0, 10'd5,    10'd9,    5'd0,  5'd0, '{FC_NONPIVOT, 5'd1, 5'd1, 1'b1, 1'b0}},
    '{PLAN_TYPED,   1'b0, 10'd7,    10'd7,    5'd0,  5'd0, '{FC_BUFFER,   5'd1, 5'd2, 1'b1, 1'b0}},
    '{PLAN_TYPED,   1'b0, 10'd8,    10'd8,    5'd0,  5'd0, '{FC_OVERFLOW, 5'd1, 5'd2, 1'b1, 1'b1}},
    '{PLAN_TYPED,   1'b0, 10'd9,    10'd5,    5'd0,  5'd0, '{FC_NONPIVOT, 5'd1, 5'd2, 1'b1, 1'b1}},
    '{PLAN_TYPED,   1'b1, 10'd9,    10'd9,    5'd0,  5'd0, '{FC_PIVOT,    5'd1, 5'd0, 1'b0, 1'b0}},
    '{PLAN_CONFIG,  1'b0, 10'd0,    10'd0,    5'd1,  5'd0, '0},
    '{PLAN_TYPED,   1'b1, 10'd1,    10'd2,    5'd0,  5'd0, '{FC_PIVOT,    5'd1, 5'd0, 1'b0, 1'b0}},
    '{PLAN_TYPED,   1'b0, 10'd3,    10'd4,    5'd0,  5'd0, '{FC_OVERFLOW, 5'd1, 5'd0, 1'b0, 1'b1}},
    '{PLAN_TYPED,   1'b0, 10'd1,    10'd4,    5'd0,  5'd0, '{FC_NONPIVOT, 5'd1, 5'd0, 1'b0, 1'b1}},
    '{PLAN_CONFIG,  1'b0, 10'd0,    10'd0,    5'd31, 5'd31, '0},
    '{PLAN_PREDICT, 1'b1, 10'd512,  10'd256,  5'd0,  5'd0, '0},
    '{PLAN_PREDICT, 1'b0, 10'd256,  10'd512,  5'd0,  5'd0, '0},
    '{PLAN_PREDICT, 1'b0, 10'd512,  10'd0,    5'd0,  5'd0, '0}
  };

  pivot_fault_classifier DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_new_array      (in_new_array),
    .in_row_addr       (in_row_addr),
    .in_col_addr       (in_col_addr),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fault_class   (out_fault_class),
    .out_pivots_held   (out_pivots_held),
    .out_buffers_held  (out_buffers_held),
    .out_buffer_in_use (out_buffer_in_use),
    .out_unrepairable  (out_unrepairable)
  );

  always #10 clk = ~clk;

  function automatic fault_verdict_t classify_fault(logic na, logic [ADDR_W-1:0] r,
                                                     logic [ADDR_W-1:0] c);
    fault_verdict_t   v;
    logic             hit;
    logic [CAP_W-1:0] pc;
    logic [CAP_W-1:0] bc;
    hit = 1'b0;
    pc  = (cap_piv > PIVOT_ENTRIES) ? CAP_W'(PIVOT_ENTRIES) : cap_piv;
    bc  = (cap_buf > BUFFER_ENTRIES) ? CAP_W'(BUFFER_ENTRIES) : cap_buf;
    if (na) begin
      piv_cnt  = '0;
      buf_cnt  = '0;
      buf_used = 1'b0;
      ovf      = 1'b0;
    end
    for (int i = 0; i < PIVOT_ENTRIES; i++) begin
      if (i < piv_cnt && (piv_row[i] == r || piv_col[i] == c)) hit = 1'b1;
    end
    if (piv_cnt == 0 || (!hit && piv_cnt < pc)) begin
      if (piv_cnt < PIVOT_ENTRIES) begin
        piv_row[piv_cnt] = r;
        piv_col[piv_cnt] = c;
        piv_cnt++;
      end
      v.cls = FC_PIVOT;
    end else if (hit) begin
      v.cls = FC_NONPIVOT;
    end else if (buf_cnt < bc) begin
      buf_cnt++;
      buf_used = 1'b1;
      v.cls = FC_BUFFER;
    end else begin
      ovf = 1'b1;
      v.cls = FC_OVERFLOW;
    end
    v.pivots  = piv_cnt;
    v.buffers = buf_cnt;
    v.in_use  = buf_used;
    v.unrep   = ovf;
    return v;
  endfunction

  task automatic drive_fault(logic na, logic [ADDR_W-1:0] r, logic [ADDR_W-1:0] c,
                             bit typed, fault_verdict_t typed_verdict);
    fault_verdict_t v;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_new_array <= na;
    in_row_addr  <= r;
    in_col_addr  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    v = classify_fault(na, r, c);
    pending_verdicts = {pending_verdicts, (typed ? typed_verdict : v)};
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_caps(logic [CAP_W-1:0] p, logic [CAP_W-1:0] b);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_PIVOT_CAP;
    cfg_wdata <= p;
    @(posedge clk);
    cap_piv = p;
    cfg_index <= REG_BUFFER_CAP;
    cfg_wdata <= b;
    @(posedge clk);
    cap_buf = b;
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, logic [4:0] want, logic [4:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual class %0d", $time,
                 out_fault_class);
        mismatches++;
      end else begin
        head = pending_verdicts.pop_front();
        check_field("fault_class", 5'(head.cls), 5'(out_fault_class));
        check_field("pivots_held", head.pivots, out_pivots_held);
        check_field("buffers_held", head.buffers, out_buffers_held);
        check_field("buffer_in_use", 5'(head.in_use), 5'(out_buffer_in_use));
        check_field("unrepairable", 5'(head.unrep), 5'(out_unrepairable));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pivot_fault_classifier_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic              na;
    logic [ADDR_W-1:0] r;
    logic [ADDR_W-1:0] c;
    int                pick;
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_PIVOT_CAP;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_new_array  = 1'b0;
    in_row_addr   = '0;
    in_col_addr   = '0;
    send_idle_pct = 32;
    recv_idle_pct = 77;
    piv_cnt       = '0;
    buf_cnt       = '0;
    buf_used      = 1'b0;
    ovf           = 1'b0;
    cap_piv       = PCAP_RESET;
    cap_buf       = BCAP_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < PLAN_LEN; k++) begin
      if (plan[k].kind == PLAN_CONFIG) begin
        write_caps(plan[k].pcap, plan[k].bcap);
      end else begin
        drive_fault(plan[k].na, plan[k].row, plan[k].col, plan[k].kind == PLAN_TYPED,
                    plan[k].want);
      end
    end

    seg_pcap[6] = CAP_W'($urandom_range(0, 31));
    seg_bcap[6] = CAP_W'($urandom_range(0, 31));
    for (int s = 0; s < SEGMENTS; s++) begin
      write_caps(seg_pcap[s], seg_bcap[s]);
      if (s == 3) begin
        send_idle_pct = 77;
        recv_idle_pct = 32;
      end else if (s == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int k = 0; k < SEG_ITEMS; k++) begin
        na   = (k == 0) ? 1'(($urandom_range(0, 1))) : ($urandom_range(0, 39) == 0);
        r    = ADDR_W'($urandom_range(0, 1023));
        c    = ADDR_W'($urandom_range(0, 1023));
        pick = $urandom_range(0, 3);
        // reuse a stored row or column so that the fault lands on a pivot line
        if (pick == 2 && piv_cnt != 0) r = piv_row[$urandom_range(0, piv_cnt - 1)];
        if (pick == 3 && piv_cnt != 0) c = piv_col[$urandom_range(0, piv_cnt - 1)];
        drive_fault(na, r, c, 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("pivot_fault_classifier_tb OK");
    end else begin
      $display("pivot_fault_classifier_tb NOT OK");
    end
    $finish;
  end

endmodule
